// File: design/wfpa_pkg.sv
// Shared constants and types for the worst-fit partition allocator.
`default_nettype none

package wfpa_pkg;

  // Storage geometry
  localparam int unsigned MaxBlocks = 8;
  localparam int unsigned BlkW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = 4;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned SumW      = 32;
  localparam int unsigned CmdW      = 2;

  // Stream payload widths (packed, padded to whole bytes)
  localparam int unsigned InDataW   = ((BlkW + SizeW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = ((BlkW + SizeW + SumW + 7) / 8) * 8;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad  = 2'd0;
  localparam logic [CmdW-1:0] CmdAlloc = 2'd1;
  localparam logic [CmdW-1:0] CmdClear = 2'd2;

  // Sequencer to search unit
  typedef struct packed {
    logic            clear;
    logic            step;
    logic [BlkW-1:0] idx;
  } scan_ctrl_t;

  // Search unit to sequencer
  typedef struct packed {
    logic             found;
    logic [BlkW-1:0]  best_idx;
    logic [SizeW-1:0] best_size;
  } scan_res_t;

endpackage

`default_nettype wire

// File: design/wfpa_scan.sv
// Worst-fit search unit: one compare step per cycle, tracks the best candidate.
`default_nettype none

module wfpa_scan (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire wfpa_pkg::scan_ctrl_t ctrl_i,
  input  wire [wfpa_pkg::SizeW-1:0] cand_size_i,
  input  wire                       cand_free_i,
  input  wire [wfpa_pkg::SizeW-1:0] req_size_i,
  output wfpa_pkg::scan_res_t       res_o
);

  logic                       found_q, found_d;
  logic [wfpa_pkg::BlkW-1:0]  best_idx_q, best_idx_d;
  logic [wfpa_pkg::SizeW-1:0] best_size_q, best_size_d;
  logic                       fits;
  logic                       better;

  // Candidate must be free and large enough; strictly larger wins so lower index keeps ties
  assign fits   = cand_free_i && (cand_size_i >= req_size_i);
  assign better = !found_q || (cand_size_i > best_size_q);

  always_comb begin
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    if (ctrl_i.clear) begin
      found_d = 1'b0;
    end else if (ctrl_i.step && fits && better) begin
      found_d     = 1'b1;
      best_idx_d  = ctrl_i.idx;
      best_size_d = cand_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
  end

  assign res_o.found     = found_q;
  assign res_o.best_idx  = best_idx_q;
  assign res_o.best_size = best_size_q;

endmodule

`default_nettype wire

// File: design/worst_fit_partition_allocator_unit.sv
// Worst-fit fixed-partition allocator: top level with sequencer and state.
//
// Usage:
//   Input stream (s_axis_*): one transaction per command. tuser carries the
//   command (load, allocate, clear); tdata carries block_index and size_value.
//   Output stream (m_axis_*): exactly one result transaction per command.
//   tuser carries the granted flag; tdata carries placed_block,
//   internal_fragment and external_total.
//   Config port: cfg_we_i writes active_blocks (partitions searched from 0);
//   write only while the block is idle.
// Sequencing:
//   Load, clear and unused commands: the sequencer goes from idle straight to its
//   Done state, which commits the result into the output register.
//   Allocate: the Scan state runs over N = min(active_blocks, 8) partitions;
//   the single compare unit visits one partition per cycle, then the Done state
//   commits and writes the result. With N = 0 the scan is skipped.
//   One command is in flight at a time; s_axis_tready is low while it works.
// Reset: occupancy flags, external total and handshake state clear; active
//   partitions return to 8; partition sizes are undefined until loaded.
// Stall: the result sits in the output register; a new command can be accepted
//   and searched meanwhile, and its commit waits until the register drains.
`default_nettype none

module worst_fit_partition_allocator_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Config
  input  wire                          cfg_we_i,
  input  wire [wfpa_pkg::CntW-1:0]     cfg_wdata_i,
  // Input stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [wfpa_pkg::InDataW-1:0]  s_axis_tdata,  // block_index, size_value, zero pad
  input  wire [wfpa_pkg::CmdW-1:0]     s_axis_tuser,  // command
  // Output stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [wfpa_pkg::OutDataW-1:0] m_axis_tdata, // placed_block, internal_fragment,
                                                      // external_total, zero pad
  output logic                         m_axis_tuser   // granted
);

  localparam int unsigned BlkW  = wfpa_pkg::BlkW;
  localparam int unsigned SizeW = wfpa_pkg::SizeW;
  localparam int unsigned SumW  = wfpa_pkg::SumW;
  localparam int unsigned CntW  = wfpa_pkg::CntW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        active_q;
  logic [CntW-1:0]        n_eff;
  logic [BlkW-1:0]        cnt_q, cnt_d;
  logic [wfpa_pkg::CmdW-1:0] cmd_q;
  logic [BlkW-1:0]        idx_q;
  logic [SizeW-1:0]       req_q;
  logic [SizeW-1:0]       sizes_q [wfpa_pkg::MaxBlocks];
  logic [wfpa_pkg::MaxBlocks-1:0] occ_q;
  logic [SumW-1:0]        sum_q;
  logic [SumW:0]          sum_add;
  logic [SumW-1:0]        sum_next;
  logic                   in_fire;
  logic                   done_fire;
  logic                   last_step;
  logic                   out_valid_q;
  logic                   out_granted_q;
  logic [BlkW-1:0]        out_block_q;
  logic [SizeW-1:0]       out_frag_q;
  logic [SumW-1:0]        out_total_q;
  logic                   grant;

  wfpa_pkg::scan_ctrl_t   scan_ctrl;
  wfpa_pkg::scan_res_t    scan_res;

  // Clamp the active count to the storage depth
  assign n_eff = (active_q > CntW'(wfpa_pkg::MaxBlocks)) ?
                 CntW'(wfpa_pkg::MaxBlocks) : active_q;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign done_fire     = (state_q == StDone) && (!out_valid_q || m_axis_tready);
  assign last_step     = ((CntW'(cnt_q) + CntW'(1)) == n_eff);

  // Search unit control
  assign scan_ctrl.clear = in_fire;
  assign scan_ctrl.step  = (state_q == StScan);
  assign scan_ctrl.idx   = cnt_q;

  wfpa_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .cand_size_i(sizes_q[cnt_q]),
    .cand_free_i(!occ_q[cnt_q]),
    .req_size_i (req_q),
    .res_o      (scan_res)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          cnt_d = '0;
          if ((s_axis_tuser == wfpa_pkg::CmdAlloc) && (n_eff != '0)) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        cnt_d = cnt_q + BlkW'(1);
        if (last_step) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (done_fire) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the accepted command
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= s_axis_tuser;
      idx_q <= s_axis_tdata[BlkW-1:0];
      req_q <= s_axis_tdata[BlkW +: SizeW];
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CntW'(wfpa_pkg::MaxBlocks);
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // Saturating add of an unplaced request
  assign sum_add  = {1'b0, sum_q} + (SumW+1)'(req_q);
  assign sum_next = sum_add[SumW] ? wfpa_pkg::SumMax : sum_add[SumW-1:0];
  assign grant    = (cmd_q == wfpa_pkg::CmdAlloc) && scan_res.found;

  // Partition sizes
  always_ff @(posedge clk_i) begin
    if (done_fire && (cmd_q == wfpa_pkg::CmdLoad)) begin
      sizes_q[idx_q] <= req_q;
    end
  end

  // Occupancy and external total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      sum_q <= '0;
    end else if (done_fire) begin
      case (cmd_q)
        wfpa_pkg::CmdAlloc: begin
          if (scan_res.found) begin
            occ_q[scan_res.best_idx] <= 1'b1;
          end else begin
            sum_q <= sum_next;
          end
        end
        wfpa_pkg::CmdClear: begin
          occ_q <= '0;
          sum_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_granted_q <= grant;
      out_block_q   <= grant ? scan_res.best_idx : '0;
      out_frag_q    <= grant ? (scan_res.best_size - req_q) : '0;
      if (cmd_q == wfpa_pkg::CmdClear) begin
        out_total_q <= '0;
      end else if ((cmd_q == wfpa_pkg::CmdAlloc) && !scan_res.found) begin
        out_total_q <= sum_next;
      end else begin
        out_total_q <= sum_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_granted_q;
  assign m_axis_tdata  = wfpa_pkg::OutDataW'({out_total_q, out_frag_q, out_block_q});

endmodule

`default_nettype wire
